>>> design/tjpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjpa_pkg
// Shared types, constants and the microcode store of the tree jump pointer
// ancestor engine.
// ----------------------------------------------------------------------------
package tjpa_pkg;

    // Table geometry
    localparam int NODE_W  = 10;
    localparam int NODES   = 1 << NODE_W;
    localparam int DIST_W  = NODE_W + 1;
    localparam int GUARD_W = NODE_W + 1;
    localparam int MODE_W  = 3;
    localparam int PC_W    = 5;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [GUARD_W-1:0] t_guard;
    typedef logic [PC_W-1:0]    t_pc;

    localparam t_node DEPTH_MAX = '1;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ROOT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_KTH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LCA  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIST = 3'd4;

    // One table entry: parent, jump pointer, depth
    typedef struct packed {
        t_node par;
        t_node jmp;
        t_node dep;
    } t_entry;

    // Table access from the datapath
    typedef struct packed {
        logic   rd0_en;
        t_node  rd0_addr;
        logic   rd1_en;
        t_node  rd1_addr;
        logic   wr_en;
        t_node  wr_addr;
        t_entry wr_data;
    } t_mem_req;

    // Datapath actions
    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_ACCEPT      = 4'd1,
        OP_ROOT_WR     = 4'd2,
        OP_ADD_SAVE    = 4'd3,
        OP_ADD_WR      = 4'd4,
        OP_GUARD_CLR   = 4'd5,
        OP_KTH_TGT     = 4'd6,
        OP_CLIMB_STEP  = 4'd7,
        OP_KTH_RES     = 4'd8,
        OP_LCA_ORDER   = 4'd9,
        OP_LCA_STEP    = 4'd10,
        OP_EMIT        = 4'd11
    } t_op;

    // Read port 0 address source
    typedef enum logic [2:0] {
        RD0_NONE       = 3'd0,
        RD0_A          = 3'd1,
        RD0_B          = 3'd2,
        RD0_NEXT_CLIMB = 3'd3,
        RD0_NEXT_A     = 3'd4
    } t_rd0_sel;

    // Read port 1 address source
    typedef enum logic [2:0] {
        RD1_NONE       = 3'd0,
        RD1_B          = 3'd1,
        RD1_Q0_JMP     = 3'd2,
        RD1_Q1_JMP     = 3'd3,
        RD1_NEXT_B     = 3'd4
    } t_rd1_sel;

    // Sequencing
    typedef enum logic [2:0] {
        BR_NEXT        = 3'd0,
        BR_GOTO        = 3'd1,
        BR_IF_GOTO     = 3'd2,
        BR_IF_STAY     = 3'd3,
        BR_DISPATCH    = 3'd4
    } t_br;

    typedef enum logic [1:0] {
        COND_NONE        = 2'd0,
        COND_CLIMB_DONE  = 2'd1,
        COND_LCA_DONE    = 2'd2,
        COND_OUT_FREE    = 2'd3
    } t_cond;

    typedef struct packed {
        t_op      op;
        t_rd0_sel rd0;
        t_rd1_sel rd1;
        t_br      br;
        t_cond    cond;
        t_pc      target;
    } t_uword;

    // Datapath conditions seen by the sequencer
    typedef struct packed {
        logic climb_done;
        logic lca_done;
        logic out_free;
    } t_status;

    // Program addresses
    localparam t_pc PC_IDLE = 5'd0;
    localparam t_pc PC_ROOT = 5'd1;
    localparam t_pc PC_A0   = 5'd2;
    localparam t_pc PC_A1   = 5'd3;
    localparam t_pc PC_A2   = 5'd4;
    localparam t_pc PC_A3   = 5'd5;
    localparam t_pc PC_K0   = 5'd6;
    localparam t_pc PC_K1   = 5'd7;
    localparam t_pc PC_KL0  = 5'd8;
    localparam t_pc PC_KL1  = 5'd9;
    localparam t_pc PC_KFIN = 5'd10;
    localparam t_pc PC_C0   = 5'd11;
    localparam t_pc PC_C1   = 5'd12;
    localparam t_pc PC_C2   = 5'd13;
    localparam t_pc PC_CL0  = 5'd14;
    localparam t_pc PC_CL1  = 5'd15;
    localparam t_pc PC_C3   = 5'd16;
    localparam t_pc PC_C4   = 5'd17;
    localparam t_pc PC_FIN  = 5'd18;

    function automatic t_uword f_uw(t_op op, t_rd0_sel rd0, t_rd1_sel rd1,
                                    t_br br, t_cond cond, t_pc target);
        t_uword w;
        w.op     = op;
        w.rd0    = rd0;
        w.rd1    = rd1;
        w.br     = br;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store
    function automatic t_uword f_ucode(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE: w = f_uw(OP_ACCEPT,     RD0_NONE, RD1_NONE,
                              BR_DISPATCH, COND_NONE, PC_IDLE);
            PC_ROOT: w = f_uw(OP_ROOT_WR,    RD0_NONE, RD1_NONE,
                              BR_GOTO, COND_NONE, PC_FIN);
            // add leaf: word(b), word(jump b), word(jump jump b), write
            PC_A0:   w = f_uw(OP_NONE,       RD0_B, RD1_NONE,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_A1:   w = f_uw(OP_NONE,       RD0_NONE, RD1_Q0_JMP,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_A2:   w = f_uw(OP_ADD_SAVE,   RD0_NONE, RD1_Q1_JMP,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_A3:   w = f_uw(OP_ADD_WR,     RD0_NONE, RD1_NONE,
                              BR_GOTO, COND_NONE, PC_FIN);
            // kth ancestor
            PC_K0:   w = f_uw(OP_GUARD_CLR,  RD0_A, RD1_NONE,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_K1:   w = f_uw(OP_KTH_TGT,    RD0_NONE, RD1_NONE,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_KL0:  w = f_uw(OP_NONE,       RD0_NONE, RD1_Q0_JMP,
                              BR_IF_GOTO, COND_CLIMB_DONE, PC_KFIN);
            PC_KL1:  w = f_uw(OP_CLIMB_STEP, RD0_NEXT_CLIMB, RD1_NONE,
                              BR_GOTO, COND_NONE, PC_KL0);
            PC_KFIN: w = f_uw(OP_KTH_RES,    RD0_NONE, RD1_NONE,
                              BR_GOTO, COND_NONE, PC_FIN);
            // common ancestor / distance
            PC_C0:   w = f_uw(OP_NONE,       RD0_A, RD1_B,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_C1:   w = f_uw(OP_LCA_ORDER,  RD0_NONE, RD1_NONE,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_C2:   w = f_uw(OP_NONE,       RD0_A, RD1_NONE,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_CL0:  w = f_uw(OP_NONE,       RD0_NONE, RD1_Q0_JMP,
                              BR_IF_GOTO, COND_CLIMB_DONE, PC_C3);
            PC_CL1:  w = f_uw(OP_CLIMB_STEP, RD0_NEXT_CLIMB, RD1_NONE,
                              BR_GOTO, COND_NONE, PC_CL0);
            PC_C3:   w = f_uw(OP_GUARD_CLR,  RD0_A, RD1_B,
                              BR_NEXT, COND_NONE, PC_IDLE);
            PC_C4:   w = f_uw(OP_LCA_STEP,   RD0_NEXT_A, RD1_NEXT_B,
                              BR_IF_STAY, COND_LCA_DONE, PC_FIN);
            PC_FIN:  w = f_uw(OP_EMIT,       RD0_NONE, RD1_NONE,
                              BR_IF_STAY, COND_OUT_FREE, PC_IDLE);
            default: w = f_uw(OP_NONE,       RD0_NONE, RD1_NONE,
                              BR_GOTO, COND_NONE, PC_IDLE);
        endcase
        return w;
    endfunction

    // Entry point of each mode
    function automatic t_pc f_entry(logic [MODE_W-1:0] mode);
        t_pc pc;
        unique case (mode)
            MODE_ROOT: pc = PC_ROOT;
            MODE_ADD:  pc = PC_A0;
            MODE_KTH:  pc = PC_K0;
            MODE_LCA,
            MODE_DIST: pc = PC_C0;
            default:   pc = PC_FIN;
        endcase
        return pc;
    endfunction

endpackage

>>> design/tjpa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjpa_seq
// Microcode sequencer: step counter, control store lookup and branching.
// ----------------------------------------------------------------------------
module tjpa_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tjpa_pkg::MODE_W-1:0]   i_mode,
    input  tjpa_pkg::t_status             i_status,
    output tjpa_pkg::t_uword              o_uword,
    output logic                          o_ready
);

    tjpa_pkg::t_pc    r_pc;
    tjpa_pkg::t_pc    n_pc;
    tjpa_pkg::t_uword w_uw;
    logic             w_cond;

    assign w_uw    = tjpa_pkg::f_ucode(r_pc);
    assign o_uword = w_uw;
    assign o_ready = (r_pc == tjpa_pkg::PC_IDLE);

    // condition select
    always_comb begin
        unique case (w_uw.cond)
            tjpa_pkg::COND_CLIMB_DONE: w_cond = i_status.climb_done;
            tjpa_pkg::COND_LCA_DONE:   w_cond = i_status.lca_done;
            tjpa_pkg::COND_OUT_FREE:   w_cond = i_status.out_free;
            default:                   w_cond = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        unique case (w_uw.br)
            tjpa_pkg::BR_NEXT:     n_pc = r_pc + 1'b1;
            tjpa_pkg::BR_GOTO:     n_pc = w_uw.target;
            tjpa_pkg::BR_IF_GOTO:  n_pc = w_cond ? w_uw.target : r_pc + 1'b1;
            tjpa_pkg::BR_IF_STAY:  n_pc = w_cond ? w_uw.target : r_pc;
            tjpa_pkg::BR_DISPATCH: n_pc = i_valid ? tjpa_pkg::f_entry(i_mode) : r_pc;
            default:               n_pc = tjpa_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tjpa_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> design/tjpa_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjpa_mem
// Node table: parent, jump and depth per node, one write and two read ports
// with registered read data that holds while its port is not read.
// ----------------------------------------------------------------------------
module tjpa_mem (
    input  logic               i_clk,
    input  tjpa_pkg::t_mem_req i_req,
    output tjpa_pkg::t_entry   o_q0,
    output tjpa_pkg::t_entry   o_q1
);

    tjpa_pkg::t_entry r_mem [tjpa_pkg::NODES];
    tjpa_pkg::t_entry r_q0;
    tjpa_pkg::t_entry r_q1;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd0_en) begin
            r_q0 <= r_mem[i_req.rd0_addr];
        end
        if (i_req.rd1_en) begin
            r_q1 <= r_mem[i_req.rd1_addr];
        end
    end

    assign o_q0 = r_q0;
    assign o_q1 = r_q1;

endmodule

>>> design/tjpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjpa_dp
// Datapath driven by the control word: node registers, target and guard,
// table address selection, result and output register.
// ----------------------------------------------------------------------------
module tjpa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tjpa_pkg::t_uword              i_uword,
    input  logic                          i_accept,
    input  logic [tjpa_pkg::MODE_W-1:0]   i_mode,
    input  tjpa_pkg::t_node               i_node_a,
    input  tjpa_pkg::t_node               i_node_b,
    input  tjpa_pkg::t_node               i_steps,
    input  logic                          i_ready,
    input  tjpa_pkg::t_entry              i_q0,
    input  tjpa_pkg::t_entry              i_q1,
    output tjpa_pkg::t_mem_req            o_req,
    output tjpa_pkg::t_status             o_status,
    output logic                          o_valid,
    output tjpa_pkg::t_node               o_result_node,
    output logic [tjpa_pkg::DIST_W-1:0]   o_distance
);

    // working registers
    logic [tjpa_pkg::MODE_W-1:0] r_mode, n_mode;
    tjpa_pkg::t_node             r_a, n_a;
    tjpa_pkg::t_node             r_b, n_b;
    tjpa_pkg::t_node             r_k, n_k;
    tjpa_pkg::t_node             r_t, n_t;
    tjpa_pkg::t_node             r_aux, n_aux;
    tjpa_pkg::t_node             r_da, n_da;
    tjpa_pkg::t_node             r_db, n_db;
    tjpa_pkg::t_guard            r_guard, n_guard;
    tjpa_pkg::t_node             r_res, n_res;
    logic [tjpa_pkg::DIST_W-1:0] r_dist, n_dist;

    // output register
    logic                        r_out_valid, n_out_valid;
    tjpa_pkg::t_node             r_out_node, n_out_node;
    logic [tjpa_pkg::DIST_W-1:0] r_out_dist, n_out_dist;

    // derived values
    tjpa_pkg::t_node             w_climb_next;
    tjpa_pkg::t_node             w_lca_next_a;
    tjpa_pkg::t_node             w_lca_next_b;
    logic                        w_jmp_differ;
    logic                        w_guard_live;
    logic                        w_climb_done;
    logic                        w_lca_done;
    logic                        w_out_free;
    tjpa_pkg::t_node             w_kth_tgt;
    tjpa_pkg::t_node             w_new_dep;
    tjpa_pkg::t_node             w_new_jmp;
    logic [tjpa_pkg::DIST_W-1:0] w_twice_ju;
    logic [tjpa_pkg::DIST_W-1:0] w_sum_jj_u;
    logic [tjpa_pkg::DIST_W:0]   w_sum_ab;
    logic [tjpa_pkg::DIST_W:0]   w_twice_res;
    logic [tjpa_pkg::DIST_W-1:0] w_dist_val;

    // climb: jump unless it overshoots the target depth
    assign w_climb_next = (i_q1.dep >= r_t) ? i_q0.jmp : i_q0.par;
    assign w_guard_live = (r_guard < tjpa_pkg::GUARD_W'(tjpa_pkg::NODES));
    assign w_climb_done = !((i_q0.dep > r_t) && w_guard_live);

    // common ancestor walk: jump both while jumps differ, else step to parents
    assign w_jmp_differ = (i_q0.jmp != i_q1.jmp);
    assign w_lca_next_a = w_jmp_differ ? i_q0.jmp : i_q0.par;
    assign w_lca_next_b = w_jmp_differ ? i_q1.jmp : i_q1.par;
    assign w_lca_done   = (r_a == r_b) || !w_guard_live;

    assign w_out_free   = !r_out_valid || i_ready;

    // kth target depth, clamped at the root
    assign w_kth_tgt = (i_q0.dep >= r_k) ? (i_q0.dep - r_k) : '0;

    // skew-binary rule for a new leaf under b (q0 = b, q1 = jump of jump of b)
    assign w_twice_ju = {r_t, 1'b0};
    assign w_sum_jj_u = {1'b0, i_q1.dep} + {1'b0, i_q0.dep};
    assign w_new_jmp  = (w_twice_ju == w_sum_jj_u) ? r_aux : r_b;
    assign w_new_dep  = (i_q0.dep < tjpa_pkg::DEPTH_MAX) ? (i_q0.dep + 1'b1)
                                                          : tjpa_pkg::DEPTH_MAX;

    // distance through the common ancestor, floored at zero
    assign w_sum_ab    = {2'b00, r_da} + {2'b00, r_db};
    assign w_twice_res = {1'b0, i_q0.dep, 1'b0};
    assign w_dist_val  = (w_sum_ab >= w_twice_res)
                         ? tjpa_pkg::DIST_W'(w_sum_ab - w_twice_res) : '0;

    assign o_status.climb_done = w_climb_done;
    assign o_status.lca_done   = w_lca_done;
    assign o_status.out_free   = w_out_free;

    // table read addresses and write
    always_comb begin
        o_req.rd0_en   = (i_uword.rd0 != tjpa_pkg::RD0_NONE);
        o_req.rd1_en   = (i_uword.rd1 != tjpa_pkg::RD1_NONE);
        unique case (i_uword.rd0)
            tjpa_pkg::RD0_B:          o_req.rd0_addr = r_b;
            tjpa_pkg::RD0_NEXT_CLIMB: o_req.rd0_addr = w_climb_next;
            tjpa_pkg::RD0_NEXT_A:     o_req.rd0_addr = w_lca_next_a;
            default:                  o_req.rd0_addr = r_a;
        endcase
        unique case (i_uword.rd1)
            tjpa_pkg::RD1_Q0_JMP:     o_req.rd1_addr = i_q0.jmp;
            tjpa_pkg::RD1_Q1_JMP:     o_req.rd1_addr = i_q1.jmp;
            tjpa_pkg::RD1_NEXT_B:     o_req.rd1_addr = w_lca_next_b;
            default:                  o_req.rd1_addr = r_b;
        endcase
        o_req.wr_addr = r_a;
        o_req.wr_en   = 1'b0;
        o_req.wr_data = '{par: r_b, jmp: w_new_jmp, dep: w_new_dep};
        if (i_uword.op == tjpa_pkg::OP_ROOT_WR) begin
            o_req.wr_en   = 1'b1;
            o_req.wr_data = '{par: r_a, jmp: r_a, dep: '0};
        end else if (i_uword.op == tjpa_pkg::OP_ADD_WR) begin
            o_req.wr_en   = 1'b1;
        end
    end

    // register updates per control word
    always_comb begin
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_t         = r_t;
        n_aux       = r_aux;
        n_da        = r_da;
        n_db        = r_db;
        n_guard     = r_guard;
        n_res       = r_res;
        n_dist      = r_dist;
        n_out_valid = r_out_valid && !i_ready;
        n_out_node  = r_out_node;
        n_out_dist  = r_out_dist;
        unique case (i_uword.op)
            tjpa_pkg::OP_ACCEPT: begin
                if (i_accept) begin
                    n_mode = i_mode;
                    n_a    = i_node_a;
                    n_b    = i_node_b;
                    n_k    = i_steps;
                    n_res  = i_node_a;
                    n_dist = '0;
                end
            end
            tjpa_pkg::OP_ADD_SAVE: begin
                n_t   = i_q1.dep;
                n_aux = i_q1.jmp;
            end
            tjpa_pkg::OP_GUARD_CLR: begin
                n_guard = '0;
            end
            tjpa_pkg::OP_KTH_TGT: begin
                n_t = w_kth_tgt;
            end
            tjpa_pkg::OP_CLIMB_STEP: begin
                n_a     = w_climb_next;
                n_guard = r_guard + 1'b1;
            end
            tjpa_pkg::OP_KTH_RES: begin
                n_res = r_a;
            end
            tjpa_pkg::OP_LCA_ORDER: begin
                n_da    = i_q0.dep;
                n_db    = i_q1.dep;
                n_guard = '0;
                if (i_q0.dep < i_q1.dep) begin
                    n_a = r_b;
                    n_b = r_a;
                    n_t = i_q0.dep;
                end else begin
                    n_t = i_q1.dep;
                end
            end
            tjpa_pkg::OP_LCA_STEP: begin
                if (w_lca_done) begin
                    n_res = r_a;
                    if (r_mode == tjpa_pkg::MODE_DIST) begin
                        n_dist = w_dist_val;
                    end
                end else begin
                    n_a     = w_lca_next_a;
                    n_b     = w_lca_next_b;
                    n_guard = r_guard + 1'b1;
                end
            end
            tjpa_pkg::OP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = r_res;
                    n_out_dist  = r_dist;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_t        <= n_t;
        r_aux      <= n_aux;
        r_da       <= n_da;
        r_db       <= n_db;
        r_guard    <= n_guard;
        r_res      <= n_res;
        r_dist     <= n_dist;
        r_out_node <= n_out_node;
        r_out_dist <= n_out_dist;
    end

    assign o_valid       = r_out_valid;
    assign o_result_node = r_out_node;
    assign o_distance    = r_out_dist;

endmodule

>>> design/tree_jump_pointer_ancestor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_jump_pointer_ancestor_engine
// Online rooted tree with skew-binary jump pointers: set root, add leaf,
// kth ancestor, common ancestor and distance queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries mode, node_a, node_b, steps.
//   Output channel (o_valid / i_ready) carries result_node and distance;
//   every item gives exactly one result, in order.
//   One item is worked on at a time; o_ready is high only while the
//   sequencer waits for an item. A finished result sits in the output
//   register, so the next item is taken while that result waits.
//   A climb step reads a node and then its jump target, because the jump
//   target's depth is a second dependent read of the node table's
//   registered port; with skew-binary jumps a query needs about
//   3*log2(depth) steps.
//   Reset clears the sequencer and the output valid; table contents are
//   not cleared and an entry must be written before it is read.
//   A stalled receiver holds the result; the sequencer waits in its last
//   step until the output register frees, then takes the next item.
// ----------------------------------------------------------------------------
module tree_jump_pointer_ancestor_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tjpa_pkg::MODE_W-1:0]   i_mode,
    input  logic [tjpa_pkg::NODE_W-1:0]   i_node_a,
    input  logic [tjpa_pkg::NODE_W-1:0]   i_node_b,
    input  logic [tjpa_pkg::NODE_W-1:0]   i_steps,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tjpa_pkg::NODE_W-1:0]   o_result_node,
    output logic [tjpa_pkg::DIST_W-1:0]   o_distance
);

    tjpa_pkg::t_uword   w_uword;
    tjpa_pkg::t_status  w_status;
    tjpa_pkg::t_mem_req w_req;
    tjpa_pkg::t_entry   w_q0;
    tjpa_pkg::t_entry   w_q1;
    logic               w_accept;

    assign w_accept = i_valid && o_ready;

    // sequencer
    tjpa_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (w_status),
        .o_uword  (w_uword),
        .o_ready  (o_ready)
    );

    // node table
    tjpa_mem u_mem (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_q0  (w_q0),
        .o_q1  (w_q1)
    );

    // datapath
    tjpa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (w_uword),
        .i_accept      (w_accept),
        .i_mode        (i_mode),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_steps       (i_steps),
        .i_ready       (i_ready),
        .i_q0          (w_q0),
        .i_q1          (w_q1),
        .o_req         (w_req),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_result_node (o_result_node),
        .o_distance    (o_distance)
    );

endmodule

>>> design/tjpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjpa_checker
// Port-level checks of the ancestor engine, bound to the top level.
// ----------------------------------------------------------------------------
module tjpa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [tjpa_pkg::NODE_W-1:0]   o_result_node,
    input logic [tjpa_pkg::DIST_W-1:0]   o_distance
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_node) && $stable(o_distance))
        else $error("result changed while stalled");

    // one item at a time: ready drops after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

    // a result is never loaded in the cycle the engine waits for an item
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared while idle");

    // distance never exceeds two full depths
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance <= 11'd2046)
        else $error("distance out of range");

endmodule

bind tree_jump_pointer_ancestor_engine tjpa_checker u_tjpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_node (o_result_node),
    .o_distance    (o_distance)
);

>>> sim/tb_tree_jump_pointer_ancestor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_jump_pointer_ancestor_engine
// Self-checking bench for the jump pointer ancestor engine. A local copy of
// the parent, jump and depth tables is updated as each item is accepted and
// gives the expected ancestor and distance. These are compared, in order,
// with the results the engine returns. Tests cover directed corner items,
// back-pressure, random forests grown in rounds with some noise, and a full
// depth chain that reaches depth saturation.
// ----------------------------------------------------------------------------
module tb_tree_jump_pointer_ancestor_engine;

    localparam logic [tjpa_pkg::MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [tjpa_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [tjpa_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 700;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    typedef struct packed {
        tjpa_pkg::t_node              node;
        logic [tjpa_pkg::DIST_W-1:0]  edges;
    } t_answer;

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        i_valid  = 1'b0;
    logic                        i_ready  = 1'b0;
    logic [tjpa_pkg::MODE_W-1:0] i_mode   = '0;
    tjpa_pkg::t_node             i_node_a = '0;
    tjpa_pkg::t_node             i_node_b = '0;
    tjpa_pkg::t_node             i_steps  = '0;
    logic                        o_ready;
    logic                        o_valid;
    tjpa_pkg::t_node             o_result_node;
    logic [tjpa_pkg::DIST_W-1:0] o_distance;

    // Local tree state
    tjpa_pkg::t_node parent_of [tjpa_pkg::NODES] = '{default: '0};
    tjpa_pkg::t_node jump_of   [tjpa_pkg::NODES] = '{default: '0};
    tjpa_pkg::t_node depth_of  [tjpa_pkg::NODES] = '{default: '0};
    bit    node_known [tjpa_pkg::NODES] = '{default: 1'b0};
    int    node_order [tjpa_pkg::NODES];

    t_answer pending_answers[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    bit      quiet          = 1'b0;
    bit      hold_request   = 1'b0;

    tree_jump_pointer_ancestor_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_steps       (i_steps),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_node (o_result_node),
        .o_distance    (o_distance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tree predictor
    // ------------------------------------------------------------------
    function automatic int depth_at(tjpa_pkg::t_node n);
        return int'(depth_of[n]);
    endfunction

    // Climb toward a target depth; jumps only where they do not overshoot
    function automatic tjpa_pkg::t_node climb_toward(tjpa_pkg::t_node n, int target);
        int guard;
        guard = 0;
        while (depth_at(n) > target && guard < tjpa_pkg::NODES) begin
            n = (depth_at(jump_of[n]) >= target) ? jump_of[n] : parent_of[n];
            guard++;
        end
        return n;
    endfunction

    function automatic tjpa_pkg::t_node common_ancestor(tjpa_pkg::t_node a,
                                                        tjpa_pkg::t_node b);
        tjpa_pkg::t_node swap;
        int              guard;
        guard = 0;
        if (depth_at(a) < depth_at(b)) begin
            swap = a;
            a    = b;
            b    = swap;
        end
        a = climb_toward(a, depth_at(b));
        while (a != b && guard < tjpa_pkg::NODES) begin
            if (jump_of[a] != jump_of[b]) begin
                a = jump_of[a];
                b = jump_of[b];
            end else begin
                a = parent_of[a];
                b = parent_of[b];
            end
            guard++;
        end
        return a;
    endfunction

    // Apply one item to the local tables and return its answer
    function automatic t_answer apply_tree_op(logic [tjpa_pkg::MODE_W-1:0] mode,
                                              tjpa_pkg::t_node a,
                                              tjpa_pkg::t_node b,
                                              tjpa_pkg::t_node k);
        t_answer         ans;
        tjpa_pkg::t_node ju, jju, nj, nd;
        int              du, target, d;
        ans.node  = a;
        ans.edges = '0;
        case (mode)
            tjpa_pkg::MODE_ROOT: begin
                parent_of[a]  = a;
                jump_of[a]    = a;
                depth_of[a]   = '0;
                node_known[a] = 1'b1;
            end
            tjpa_pkg::MODE_ADD: begin
                ju  = jump_of[b];
                jju = jump_of[ju];
                du  = depth_at(b);
                nd  = (du < int'(tjpa_pkg::DEPTH_MAX)) ? tjpa_pkg::t_node'(du + 1)
                                                       : tjpa_pkg::DEPTH_MAX;
                // skew-binary rule: equal spans merge into one longer jump
                nj  = (2 * depth_at(ju) == depth_at(jju) + du) ? jju : b;
                parent_of[a]  = b;
                depth_of[a]   = nd;
                jump_of[a]    = nj;
                node_known[a] = 1'b1;
            end
            tjpa_pkg::MODE_KTH: begin
                target = depth_at(a) - int'(k);
                if (target < 0)
                    target = 0;
                ans.node = climb_toward(a, target);
            end
            tjpa_pkg::MODE_LCA, tjpa_pkg::MODE_DIST: begin
                ans.node = common_ancestor(a, b);
                if (mode == tjpa_pkg::MODE_DIST) begin
                    d = depth_at(a) + depth_at(b) - 2 * depth_at(ans.node);
                    ans.edges = (d < 0) ? '0 : d[tjpa_pkg::DIST_W-1:0];
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic tjpa_pkg::t_node rand_node();
        return tjpa_pkg::t_node'($urandom_range(0, tjpa_pkg::NODES - 1));
    endfunction

    function automatic tjpa_pkg::t_node known_node();
        tjpa_pkg::t_node n;
        do
            n = rand_node();
        while (!node_known[n]);
        return n;
    endfunction

    function automatic tjpa_pkg::t_node pick_steps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return tjpa_pkg::t_node'($urandom_range(0, 7));
        else if (r < 70)
            return '1;
        else if (r < 85)
            return tjpa_pkg::t_node'($urandom_range(8, 63));
        else
            return rand_node();
    endfunction

    function automatic logic [tjpa_pkg::MODE_W-1:0] pick_query_mode();
        case ($urandom_range(0, 2))
            0:       return tjpa_pkg::MODE_KTH;
            1:       return tjpa_pkg::MODE_LCA;
            default: return tjpa_pkg::MODE_DIST;
        endcase
    endfunction

    function automatic void shuffle_nodes();
        int j, t;
        for (int i = tjpa_pkg::NODES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = node_order[i];
            node_order[i] = node_order[j];
            node_order[j] = t;
        end
    endfunction

    // Offer one item, wait for acceptance, record its expected answer.
    // Entered and left at a falling edge; valid stays high between items unless a gap is drawn.
    task automatic send_item(input logic [tjpa_pkg::MODE_W-1:0] mode,
                             input tjpa_pkg::t_node a, input tjpa_pkg::t_node b,
                             input tjpa_pkg::t_node k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_node_a <= a;
        i_node_b <= b;
        i_steps  <= k;
        do
            @(posedge i_clk);
        while (o_ready !== 1'b1);
        pending_answers.push_back(apply_tree_op(mode, a, b, k));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue_query(input tjpa_pkg::t_node pool[$]);
        send_item(pick_query_mode(), pool[$urandom_range(0, pool.size() - 1)],
                  pool[$urandom_range(0, pool.size() - 1)], pick_steps());
    endtask

    // Spare modes, stale nodes, re-rooting and cycle-making adds
    task automatic issue_noise(input tjpa_pkg::t_node pool[$]);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_item($urandom_range(0, 2) == 0 ? MODE_SPARE5 :
                      ($urandom_range(0, 1) == 0 ? MODE_SPARE6 : MODE_SPARE7),
                      rand_node(), rand_node(), rand_node());
        else if (r < 70)
            send_item(pick_query_mode(), known_node(), known_node(), pick_steps());
        else if (r < 88)
            send_item(tjpa_pkg::MODE_ROOT, pool[$urandom_range(0, pool.size() - 1)],
                      rand_node(), rand_node());
        else
            send_item(tjpa_pkg::MODE_ADD, pool[$urandom_range(0, pool.size() - 1)],
                      pool[$urandom_range(0, pool.size() - 1)], rand_node());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // field extremes and a small tree
        send_item(tjpa_pkg::MODE_ROOT, 10'd0,    10'd1023, 10'd1023);
        send_item(tjpa_pkg::MODE_ROOT, 10'd1023, 10'd0,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd5,    10'd0,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd6,    10'd5,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd7,    10'd6,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd8,    10'd7,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd9,    10'd5,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd1022, 10'd1023, 10'd1023);
        // kth ancestor: zero steps, a few, and far past the root
        send_item(tjpa_pkg::MODE_KTH,  10'd8,    10'd0,    10'd0);
        send_item(tjpa_pkg::MODE_KTH,  10'd8,    10'd0,    10'd2);
        send_item(tjpa_pkg::MODE_KTH,  10'd8,    10'd1023, 10'd1023);
        // common ancestor: siblings' branches, a node with itself, disjoint trees
        send_item(tjpa_pkg::MODE_LCA,  10'd8,    10'd9,    10'd0);
        send_item(tjpa_pkg::MODE_LCA,  10'd8,    10'd8,    10'd0);
        send_item(tjpa_pkg::MODE_LCA,  10'd8,    10'd1022, 10'd0);
        send_item(tjpa_pkg::MODE_DIST, 10'd8,    10'd9,    10'd0);
        send_item(tjpa_pkg::MODE_DIST, 10'd9,    10'd0,    10'd0);
        // spare modes leave the tables alone
        send_item(MODE_SPARE5, 10'd1023, 10'd1023, 10'd1023);
        send_item(MODE_SPARE6, 10'd0,    10'd0,    10'd0);
        send_item(MODE_SPARE7, 10'd512,  10'd341,  10'd682);
        // two nodes made each other's parent: guarded climbs, distance below zero
        send_item(tjpa_pkg::MODE_ROOT, 10'd900,  10'd0,    10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd901,  10'd900,  10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd900,  10'd901,  10'd0);
        send_item(tjpa_pkg::MODE_KTH,  10'd900,  10'd0,    10'd1);
        send_item(tjpa_pkg::MODE_DIST, 10'd901,  10'd0,    10'd0);
    endtask

    // Receiver holds off while items keep coming; input side must stall
    task automatic test_backpressure();
        send_item(tjpa_pkg::MODE_ROOT, 10'd300, 10'd0,   10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd301, 10'd300, 10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd302, 10'd301, 10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd303, 10'd302, 10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd304, 10'd301, 10'd0);
        send_item(tjpa_pkg::MODE_ADD,  10'd305, 10'd304, 10'd0);
        quiet        = 1'b1;
        hold_request = 1'b1;
        repeat (12)
            issue_query('{10'd300, 10'd301, 10'd302, 10'd303, 10'd304, 10'd305});
        quiet = 1'b0;
    endtask

    // Forests grown in rounds over fresh random node sets
    task automatic test_random_forest(input int item_goal);
        tjpa_pkg::t_node placed[$];
        tjpa_pkg::t_node nd;
        int              stop_at, n, roots, pick, span;
        stop_at = items_sent + item_goal;
        while (items_sent < stop_at) begin
            shuffle_nodes();
            placed.delete();
            quiet = ($urandom_range(0, 4) == 0);
            n     = $urandom_range(6, 48);
            roots = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                nd = tjpa_pkg::t_node'(node_order[i]);
                if (i < roots) begin
                    send_item(tjpa_pkg::MODE_ROOT, nd, rand_node(), rand_node());
                end else begin
                    // mostly hang under recent nodes to get some depth
                    span = (placed.size() > 4) ? 3 : placed.size() - 1;
                    if ($urandom_range(0, 9) < 7)
                        pick = placed.size() - 1 - $urandom_range(0, span);
                    else
                        pick = $urandom_range(0, placed.size() - 1);
                    send_item(tjpa_pkg::MODE_ADD, nd, placed[pick], rand_node());
                end
                placed.push_back(nd);
                repeat ($urandom_range(0, 2))
                    issue_query(placed);
                if ($urandom_range(0, 99) < 8)
                    issue_noise(placed);
            end
        end
        quiet = 1'b0;
    endtask

    // One chain through every node: deepest possible tree and depth saturation
    task automatic test_deep_chain();
        tjpa_pkg::t_node chain[tjpa_pkg::NODES];
        int              i;
        shuffle_nodes();
        for (i = 0; i < tjpa_pkg::NODES; i++)
            chain[i] = tjpa_pkg::t_node'(node_order[i]);
        send_item(tjpa_pkg::MODE_ROOT, chain[0], rand_node(), rand_node());
        for (i = 1; i < tjpa_pkg::NODES; i++) begin
            send_item(tjpa_pkg::MODE_ADD, chain[i], chain[i-1], rand_node());
            if (i % 64 == 0)
                send_item(tjpa_pkg::MODE_KTH, chain[i], rand_node(), pick_steps());
        end
        send_item(tjpa_pkg::MODE_KTH, chain[tjpa_pkg::NODES-1], rand_node(), 10'd1023);
        send_item(tjpa_pkg::MODE_KTH, chain[tjpa_pkg::NODES-1], rand_node(), 10'd0);
        send_item(tjpa_pkg::MODE_KTH, chain[tjpa_pkg::NODES-1], rand_node(), 10'd1000);
        repeat (10)
            send_item(tjpa_pkg::MODE_KTH, chain[$urandom_range(0, tjpa_pkg::NODES - 1)],
                      rand_node(), rand_node());
        repeat (10)
            send_item($urandom_range(0, 1) ? tjpa_pkg::MODE_LCA : tjpa_pkg::MODE_DIST,
                      chain[$urandom_range(0, tjpa_pkg::NODES - 1)],
                      chain[$urandom_range(0, tjpa_pkg::NODES - 1)], rand_node());
        // parent already at the largest depth: leaf depth saturates
        send_item(tjpa_pkg::MODE_ADD, chain[tjpa_pkg::NODES-1], chain[tjpa_pkg::NODES-1],
                  rand_node());
        send_item(tjpa_pkg::MODE_KTH, chain[tjpa_pkg::NODES-1], rand_node(), 10'd3);
        send_item(tjpa_pkg::MODE_DIST, chain[tjpa_pkg::NODES-1],
                  chain[tjpa_pkg::NODES/2], rand_node());
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, one long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (quiet || $urandom_range(0, 99) < 70) begin
                i_ready <= 1'b1;
            end else begin
                stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Compare each returned result with the oldest expected answer
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t ERROR: unexpected result node %0d distance %0d",
                         $time, o_result_node, o_distance);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_result_node !== want.node) begin
                    $display("%0t ERROR: result_node expected %0d actual %0d",
                             $time, want.node, o_result_node);
                    mismatch_count++;
                end
                if (o_distance !== want.edges) begin
                    $display("%0t ERROR: distance expected %0d actual %0d",
                             $time, want.edges, o_distance);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main_flow
        int drain_wait;
        for (int i = 0; i < tjpa_pkg::NODES; i++)
            node_order[i] = i;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_forest(RANDOM_ITEMS);
        test_deep_chain();

        i_valid <= 1'b0;
        drain_wait = 0;
        while (pending_answers.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $display("%0t ERROR: %0d expected results never arrived",
                     $time, pending_answers.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop in case the engine hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t ERROR: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
